### rtl/core/stfr_pkg.sv
package stfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int SLOT_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int PAYLOAD_LEN = 7;
    localparam int COUNT_W     = 3;
    // Eight bytes of at most 0xFF each fit in eleven bits.
    localparam int SUM_W       = 11;

    localparam logic [BYTE_W-1:0] FRAME_MARK = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_MARK   = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FLIP   = 8'h20;
    localparam logic [BYTE_W-1:0] GOOD_SUM   = 8'hFF;

    localparam logic [BYTE_W-1:0] OWN_ID_RESET    = 8'h1B;
    localparam logic [BYTE_W-1:0] LISTEN_ID_RESET = 8'h0D;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ID    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LISTEN_ID = 2'd1;

    localparam logic [SLOT_W-1:0] SLOT_NONE   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_REVOKE = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_GRANT  = 2'd2;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       rx_idle;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  slot_event;
        logic        frame_valid;
        logic [7:0]  frame_kind;
        logic [15:0] value_ident;
        logic [31:0] value_word;
    } t_out_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] own_id;
        logic [BYTE_W-1:0] listen_id;
    } t_cfg;

endpackage

### rtl/core/stfr_cfg_regs.sv
module stfr_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [stfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [stfr_pkg::BYTE_W-1:0]       i_cfg_data,
    output stfr_pkg::t_cfg                    o_cfg
);

    stfr_pkg::t_cfg r_cfg;
    stfr_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                stfr_pkg::REG_OWN_ID:    n_cfg.own_id    = i_cfg_data;
                stfr_pkg::REG_LISTEN_ID: n_cfg.listen_id = i_cfg_data;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_id    <= stfr_pkg::OWN_ID_RESET;
            r_cfg.listen_id <= stfr_pkg::LISTEN_ID_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/core/stfr_decoder.sv
module stfr_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  stfr_pkg::t_in_beat   i_beat,
    input  stfr_pkg::t_cfg       i_cfg,
    output stfr_pkg::t_out_beat  o_result
);

    logic [stfr_pkg::BYTE_W-1:0]  r_store [stfr_pkg::PAYLOAD_LEN];
    logic [stfr_pkg::BYTE_W-1:0]  n_store [stfr_pkg::PAYLOAD_LEN];
    logic [stfr_pkg::COUNT_W-1:0] r_count;
    logic [stfr_pkg::COUNT_W-1:0] n_count;
    logic                         r_skipping;
    logic                         n_skipping;
    logic                         r_expect_id;
    logic                         n_expect_id;
    logic                         r_escape;
    logic                         n_escape;
    logic [stfr_pkg::SUM_W-1:0]   r_sum;
    logic [stfr_pkg::SUM_W-1:0]   n_sum;

    logic [stfr_pkg::BYTE_W-1:0]  data_byte;
    logic [stfr_pkg::SUM_W-1:0]   sum_total;
    logic [stfr_pkg::BYTE_W:0]    folded;
    logic [stfr_pkg::SLOT_W-1:0]  slot;
    logic                         valid;

    assign data_byte = r_escape ? (i_beat.line_byte ^ stfr_pkg::ESC_FLIP) : i_beat.line_byte;
    assign sum_total = r_sum + {{(stfr_pkg::SUM_W-stfr_pkg::BYTE_W){1'b0}}, data_byte};
    // Fold the carries back in once.
    assign folded = {1'b0, sum_total[stfr_pkg::BYTE_W-1:0]}
                  + {{(2*stfr_pkg::BYTE_W+1-stfr_pkg::SUM_W){1'b0}},
                     sum_total[stfr_pkg::SUM_W-1:stfr_pkg::BYTE_W]};

    always_comb begin
        n_store     = r_store;
        n_count     = r_count;
        n_skipping  = r_skipping;
        n_expect_id = r_expect_id;
        n_escape    = r_escape;
        n_sum       = r_sum;
        slot        = stfr_pkg::SLOT_NONE;
        valid       = 1'b0;
        if (i_beat.line_byte == stfr_pkg::FRAME_MARK) begin
            // A pending escape survives the start mark.
            slot        = stfr_pkg::SLOT_REVOKE;
            n_count     = '0;
            n_expect_id = 1'b1;
            n_skipping  = 1'b0;
        end else if (!r_skipping) begin
            if (r_expect_id) begin
                n_expect_id = 1'b0;
                if (i_beat.line_byte == i_cfg.own_id && i_beat.rx_idle) begin
                    slot       = stfr_pkg::SLOT_GRANT;
                    n_skipping = 1'b1;
                end else if (i_beat.line_byte == i_cfg.listen_id) begin
                    n_sum = '0;
                end else begin
                    n_skipping = 1'b1;
                end
            end else if (i_beat.line_byte == stfr_pkg::ESC_MARK) begin
                n_escape = 1'b1;
            end else begin
                n_escape = 1'b0;
                if (r_count < stfr_pkg::COUNT_W'(stfr_pkg::PAYLOAD_LEN)) begin
                    n_store[r_count] = data_byte;
                    n_count          = r_count + 1'b1;
                    n_sum            = sum_total;
                end else begin
                    n_skipping = 1'b1;
                    n_sum      = stfr_pkg::SUM_W'(folded);
                    valid      = (folded == {1'b0, stfr_pkg::GOOD_SUM});
                end
            end
        end
    end

    always_comb begin
        o_result.slot_event  = slot;
        o_result.frame_valid = valid;
        o_result.frame_kind  = '0;
        o_result.value_ident = '0;
        o_result.value_word  = '0;
        if (valid) begin
            o_result.frame_kind  = r_store[0];
            o_result.value_ident = {r_store[2], r_store[1]};
            o_result.value_word  = {r_store[6], r_store[5], r_store[4], r_store[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_skipping  <= 1'b1;
            r_expect_id <= 1'b0;
            r_escape    <= 1'b0;
            r_sum       <= '0;
        end else if (i_advance) begin
            r_count     <= n_count;
            r_skipping  <= n_skipping;
            r_expect_id <= n_expect_id;
            r_escape    <= n_escape;
            r_sum       <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_store <= n_store;
        end
    end

endmodule

### rtl/core/stuffed_telemetry_frame_receiver_top.sv
// Byte-stuffed telemetry frame receiver: one line byte per beat in, exactly
// one result beat out per byte, in order. A byte is registered, then decoded
// against the frame state and written to the result register, so a new
// byte is taken every cycle while the result side keeps up; a stalled
// result holds the decode stage, and the input register takes a beat only
// while it is empty. The own and listened sensor ids are written through
// the configuration port (index 0 and 1); the user must write them while no
// byte is in flight, which the block does not enforce. That port never stalls.
module stuffed_telemetry_frame_receiver_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  stfr_pkg::t_in_beat                i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output stfr_pkg::t_out_beat               o_out_beat,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [stfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [stfr_pkg::BYTE_W-1:0]       i_cfg_data
);

    stfr_pkg::t_cfg       cfg;
    stfr_pkg::t_out_beat  result;
    logic                 advance;

    logic                 r_in_valid;
    stfr_pkg::t_in_beat   r_in_beat;
    logic                 r_out_valid;
    stfr_pkg::t_out_beat  r_out_beat;

    // Advance the held byte when the result register is free or draining.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    stfr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    stfr_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_beat    (r_in_beat),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
        if (advance) begin
            r_out_beat <= result;
        end
    end

endmodule

### tb/sv/stfr_checker.sv
`timescale 1ns / 1ps

module stfr_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  stfr_pkg::t_in_beat               i_in_beat,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  stfr_pkg::t_out_beat              i_out_beat,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [stfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [stfr_pkg::BYTE_W-1:0]      i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    logic [stfr_pkg::BYTE_W-1:0] own_id;
    logic [stfr_pkg::BYTE_W-1:0] listen_id;
    logic [stfr_pkg::BYTE_W-1:0] payload_bytes [stfr_pkg::PAYLOAD_LEN];
    logic [2:0]                  frame_pos;
    logic                        skip_frame;
    logic                        await_id;
    logic                        esc_armed;
    logic [15:0]                 frame_sum;
    stfr_pkg::t_out_beat         expected_results [$];
    int                          fail_count = 0;

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Advance the frame state by one line byte and work out its result beat.
    task automatic decode_line_byte(input stfr_pkg::t_in_beat beat,
                                    output stfr_pkg::t_out_beat res);
        logic [stfr_pkg::BYTE_W-1:0] b;
        logic [15:0]                 folded;
        b   = beat.line_byte;
        res = '0;
        if (b == stfr_pkg::FRAME_MARK) begin
            res.slot_event = stfr_pkg::SLOT_REVOKE;
            frame_pos      = '0;
            await_id       = 1'b1;
            skip_frame     = 1'b0;
        end else if (!skip_frame) begin
            if (await_id) begin
                await_id = 1'b0;
                if (b == own_id && beat.rx_idle) begin
                    res.slot_event = stfr_pkg::SLOT_GRANT;
                    skip_frame     = 1'b1;
                end else if (b == listen_id) begin
                    frame_sum = '0;
                end else begin
                    skip_frame = 1'b1;
                end
            end else if (b == stfr_pkg::ESC_MARK) begin
                esc_armed = 1'b1;
            end else begin
                if (esc_armed) begin
                    b         = b ^ stfr_pkg::ESC_FLIP;
                    esc_armed = 1'b0;
                end
                frame_sum = frame_sum + 16'(b);
                if (frame_pos < 3'(stfr_pkg::PAYLOAD_LEN)) begin
                    payload_bytes[frame_pos] = b;
                    frame_pos                = frame_pos + 3'd1;
                end else begin
                    // Checksum byte: fold once with end-around carry.
                    skip_frame = 1'b1;
                    folded     = (frame_sum & 16'h00FF) + (frame_sum >> 8);
                    frame_sum  = folded;
                    if (folded == {8'h00, stfr_pkg::GOOD_SUM}) begin
                        res.frame_valid = 1'b1;
                        res.frame_kind  = payload_bytes[0];
                        res.value_ident = {payload_bytes[2], payload_bytes[1]};
                        res.value_word  = {payload_bytes[6], payload_bytes[5],
                                           payload_bytes[4], payload_bytes[3]};
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        stfr_pkg::t_out_beat predicted;
        stfr_pkg::t_out_beat oldest;
        if (!i_rst_n) begin
            own_id     = stfr_pkg::OWN_ID_RESET;
            listen_id  = stfr_pkg::LISTEN_ID_RESET;
            frame_pos  = '0;
            skip_frame = 1'b1;
            await_id   = 1'b0;
            esc_armed  = 1'b0;
            frame_sum  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == stfr_pkg::REG_OWN_ID) begin
                    own_id = i_cfg_data;
                end else if (i_cfg_index == stfr_pkg::REG_LISTEN_ID) begin
                    listen_id = i_cfg_data;
                end
            end
            // Pop before push: a result never belongs to a byte taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expected result: 0x%0h", i_out_beat);
                    fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    compare_field("slot_event", 32'(oldest.slot_event),
                                  32'(i_out_beat.slot_event));
                    compare_field("frame_valid", 32'(oldest.frame_valid),
                                  32'(i_out_beat.frame_valid));
                    compare_field("frame_kind", 32'(oldest.frame_kind),
                                  32'(i_out_beat.frame_kind));
                    compare_field("value_ident", 32'(oldest.value_ident),
                                  32'(i_out_beat.value_ident));
                    compare_field("value_word", oldest.value_word, i_out_beat.value_word);
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_line_byte(i_in_beat, predicted);
                expected_results.push_back(predicted);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef enum int {SHAPE_GOOD, SHAPE_BAD_SUM, SHAPE_CUT} t_shape;

    logic                             clk;
    logic                             rst_n      = 1'b0;
    logic                             in_valid   = 1'b0;
    stfr_pkg::t_in_beat               in_beat    = '0;
    logic                             in_ready;
    logic                             out_valid;
    logic                             out_ready  = 1'b0;
    stfr_pkg::t_out_beat              out_beat;
    logic                             cfg_valid  = 1'b0;
    logic [stfr_pkg::CFG_INDEX_W-1:0] cfg_index  = stfr_pkg::REG_OWN_ID;
    logic [stfr_pkg::BYTE_W-1:0]      cfg_data   = '0;
    logic                             cfg_ready;
    int                               fail_count;
    int                               pending;
    logic                             quiet      = 1'b0;
    int                               stall_left = 0;
    int                               items_sent = 0;
    logic [stfr_pkg::BYTE_W-1:0]      cur_own    = stfr_pkg::OWN_ID_RESET;
    logic [stfr_pkg::BYTE_W-1:0]      cur_listen = stfr_pkg::LISTEN_ID_RESET;

    stuffed_telemetry_frame_receiver_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    stfr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    // Result side: random stall bursts.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [stfr_pkg::BYTE_W-1:0] b, input logic idle);
        stfr_pkg::t_in_beat beat;
        beat.line_byte = b;
        beat.rx_idle   = idle;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Stuff a decoded byte onto the line; carried means an escape is already pending.
    task automatic send_data_byte(input logic [stfr_pkg::BYTE_W-1:0] b, input logic carried);
        logic [stfr_pkg::BYTE_W-1:0] flipped;
        flipped = b ^ stfr_pkg::ESC_FLIP;
        if (carried) begin
            send_beat(flipped, 1'($urandom_range(0, 1)));
        end else if (b == stfr_pkg::FRAME_MARK || b == stfr_pkg::ESC_MARK ||
                     (flipped != stfr_pkg::FRAME_MARK && flipped != stfr_pkg::ESC_MARK &&
                      $urandom_range(0, 9) == 0)) begin
            // A doubled escape leaves the escape pending.
            if ($urandom_range(0, 7) == 0) begin
                send_beat(stfr_pkg::ESC_MARK, 1'($urandom_range(0, 1)));
            end
            send_beat(stfr_pkg::ESC_MARK, 1'($urandom_range(0, 1)));
            send_beat(flipped, 1'($urandom_range(0, 1)));
        end else begin
            send_beat(b, 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic logic [8*stfr_pkg::PAYLOAD_LEN-1:0] rand_payload();
        logic [8*stfr_pkg::PAYLOAD_LEN-1:0] pl;
        for (int i = 0; i < stfr_pkg::PAYLOAD_LEN; i++) begin
            case ($urandom_range(0, 7))
                0:       pl[8*i +: 8] = stfr_pkg::FRAME_MARK;
                1:       pl[8*i +: 8] = stfr_pkg::ESC_MARK;
                2:       pl[8*i +: 8] = 8'h00;
                3:       pl[8*i +: 8] = 8'hFF;
                default: pl[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return pl;
    endfunction

    task automatic send_frame(input logic [stfr_pkg::BYTE_W-1:0] id, input logic id_idle,
                              input logic [8*stfr_pkg::PAYLOAD_LEN-1:0] pl,
                              input t_shape shape, input logic esc_carried);
        logic [15:0]                 sum;
        logic [15:0]                 x;
        logic [stfr_pkg::BYTE_W-1:0] chk;
        logic [stfr_pkg::BYTE_W-1:0] flip_bits;
        int                          keep;
        send_beat(stfr_pkg::FRAME_MARK, 1'($urandom_range(0, 1)));
        send_beat(id, id_idle);
        keep = (shape == SHAPE_CUT) ? $urandom_range(0, stfr_pkg::PAYLOAD_LEN)
                                    : stfr_pkg::PAYLOAD_LEN;
        sum  = '0;
        for (int i = 0; i < keep; i++) begin
            send_data_byte(pl[8*i +: 8], esc_carried && i == 0);
            sum = sum + 16'(pl[8*i +: 8]);
        end
        if (shape != SHAPE_CUT) begin
            chk = '0;
            for (int c = 0; c < 256; c++) begin
                x = sum + 16'(c);
                if (((x & 16'h00FF) + (x >> 8)) == {8'h00, stfr_pkg::GOOD_SUM}) chk = 8'(c);
            end
            if (shape == SHAPE_BAD_SUM) begin
                flip_bits = 8'($urandom_range(1, 255));
                chk       = chk ^ flip_bits;
            end
            send_data_byte(chk, 1'b0);
        end
    endtask

    task automatic send_noise();
        logic [stfr_pkg::BYTE_W-1:0] b;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 5))
                0:       b = stfr_pkg::FRAME_MARK;
                1:       b = stfr_pkg::ESC_MARK;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_beat(b, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(input int n);
        int                          target;
        int                          pick;
        logic [stfr_pkg::BYTE_W-1:0] other;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame(cur_listen, 1'($urandom_range(0, 1)), rand_payload(), SHAPE_GOOD,
                           1'b0);
            end else if (pick < 65) begin
                send_frame(cur_listen, 1'($urandom_range(0, 1)), rand_payload(),
                           SHAPE_BAD_SUM, 1'b0);
            end else if (pick < 72) begin
                send_frame(cur_listen, 1'($urandom_range(0, 1)), rand_payload(), SHAPE_CUT,
                           1'b0);
            end else if (pick < 82) begin
                send_frame(cur_own, 1'($urandom_range(0, 1)), rand_payload(), SHAPE_GOOD,
                           1'b0);
            end else if (pick < 90) begin
                other = 8'($urandom_range(0, 255));
                if (other == stfr_pkg::FRAME_MARK) other = 8'h00;
                send_frame(other, 1'($urandom_range(0, 1)), rand_payload(), SHAPE_GOOD,
                           1'b0);
            end else begin
                send_noise();
            end
        end
    endtask

    // Wait for every expected result, then let the two-stage pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [stfr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [stfr_pkg::BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [stfr_pkg::BYTE_W-1:0] own,
                             input logic [stfr_pkg::BYTE_W-1:0] listen, input int n);
        drain();
        write_reg(stfr_pkg::REG_OWN_ID, own);
        write_reg(stfr_pkg::REG_LISTEN_ID, listen);
        cur_own    = own;
        cur_listen = listen;
        run_random(n);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Grant on own id with an idle line, skip on own id with a busy line.
        send_beat(stfr_pkg::FRAME_MARK, 1'b1);
        send_beat(stfr_pkg::OWN_ID_RESET, 1'b1);
        send_beat(stfr_pkg::FRAME_MARK, 1'b0);
        send_beat(stfr_pkg::OWN_ID_RESET, 1'b0);
        send_beat(8'h00, 1'b1);
        send_frame(stfr_pkg::LISTEN_ID_RESET, 1'b0, {stfr_pkg::PAYLOAD_LEN{8'hFF}},
                   SHAPE_GOOD, 1'b0);
        // Escape pending across a frame mark carries into the next frame.
        send_beat(stfr_pkg::FRAME_MARK, 1'b0);
        send_beat(stfr_pkg::LISTEN_ID_RESET, 1'b1);
        send_beat(stfr_pkg::ESC_MARK, 1'b0);
        send_frame(stfr_pkg::LISTEN_ID_RESET, 1'b1,
                   {8'h00, 8'h5E, 8'h5D, 8'hFF, stfr_pkg::ESC_MARK, stfr_pkg::FRAME_MARK,
                    8'h41},
                   SHAPE_GOOD, 1'b1);

        run_random(250);
        run_phase(8'h00, 8'hFF, 250);
        run_phase(8'hFF, 8'h00, 250);
        run_phase(8'h5A, 8'h5A, 250);
        run_phase(stfr_pkg::ESC_MARK, stfr_pkg::FRAME_MARK, 200);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 250);
        quiet <= 1'b1;
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 300);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### stuffed_telemetry_frame_receiver_top.f
rtl/core/stfr_pkg.sv
rtl/core/stfr_cfg_regs.sv
rtl/core/stfr_decoder.sv
rtl/core/stuffed_telemetry_frame_receiver_top.sv
tb/sv/stfr_checker.sv
tb/sv/tb.sv
